// ===== rtl/core/ptmt_pkg.sv =====
package ptmt_pkg;

    localparam int TABLE_PAGES   = 64;
    localparam int PAGE_ENTRIES  = 512;
    localparam int STORE_ENTRIES = TABLE_PAGES * PAGE_ENTRIES;
    localparam int PG_W          = $clog2(TABLE_PAGES);
    localparam int ADDR_W        = $clog2(STORE_ENTRIES);

    localparam logic [15:0] MARK_TABLE  = 16'h4444;
    localparam logic [15:0] MARK_MAPPED = 16'hf3f0;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_MAP       = 2'd1,
        OP_WRITE     = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MAPPED  = 2'd1,
        ST_OUTSIDE = 2'd2,
        ST_NOFREE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SZ_4K = 2'd0,
        SZ_2M = 2'd1,
        SZ_1G = 2'd2
    } size_t_t;

    typedef enum logic [0:0] {
        REG_ROOT  = 1'b0,
        REG_ALLOC = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RAW,
        S_RD,
        S_EVAL,
        S_ZERO,
        S_LINK
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [47:0] virt_addr;
        logic [51:0] target_pa;
        logic [14:0] entry_index;
        logic [63:0] entry_value;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [51:0] translated_addr;
        logic [1:0]  size_code;
        logic [63:0] read_data;
    } rsp_t;

    typedef struct packed {
        req_t req;
        logic idx_ok;
    } work_t;

    function automatic logic [15:0] avail_of(input logic [63:0] v);
        return {v[62:52], v[11:8], v[6]};
    endfunction

    function automatic logic [63:0] put_avail(input logic [63:0] v, input logic [15:0] a);
        logic [63:0] r;
        r = v;
        r[11:8]  = a[4:1];
        r[62:52] = a[15:5];
        return r;
    endfunction

    function automatic logic page_ok(input logic [63:0] e);
        return {12'd0, e[51:12]} < 52'(TABLE_PAGES);
    endfunction

endpackage

// ===== rtl/core/ptmt_ram.sv =====
module ptmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ptmt_front.sv =====
module ptmt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  ptmt_pkg::req_t  req,
    input  logic            hold,
    output logic            q_valid,
    output ptmt_pkg::work_t q_head,
    input  logic            q_pop
);
    import ptmt_pkg::*;

    work_t      slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2) || hold;
    assign do_push = push && !full;
    assign q_valid = cnt_reg != 2'd0;
    assign do_pop  = q_pop && q_valid;
    assign q_head  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg].req    <= req;
            slot_reg[wp_reg].idx_ok <= {17'd0, req.entry_index} < 32'(STORE_ENTRIES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== rtl/core/ptmt_back.sv =====
module ptmt_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  q_valid,
    input  ptmt_pkg::work_t       q_head,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  res_valid,
    output ptmt_pkg::rsp_t        rsp,
    input  logic                  pop
);
    import ptmt_pkg::*;

    state_t            state_reg, state_next;
    req_t              item_reg, item_next;
    logic [1:0]        lvl_reg, lvl_next;
    logic [PG_W-1:0]   pg_reg, pg_next;
    logic [PG_W-1:0]   np_reg, np_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [63:0]       ent_reg, ent_next;
    logic [5:0]        root_reg;
    logic [6:0]        nfp_reg, nfp_next;
    logic              res_valid_reg, res_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr, slot;
    logic [63:0]       wdata, rdata, e, lnk;
    logic [8:0]        sl;

    ptmt_ram #(.WIDTH(64), .DEPTH(STORE_ENTRIES)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign clearing  = state_reg == S_CLEAR;
    assign res_valid = res_valid_reg;
    assign rsp       = rsp_reg;
    assign e         = rdata;

    always_comb
    begin
        case (lvl_reg)
            2'd0:    sl = item_reg.virt_addr[47:39];
            2'd1:    sl = item_reg.virt_addr[38:30];
            2'd2:    sl = item_reg.virt_addr[29:21];
            default: sl = item_reg.virt_addr[20:12];
        endcase
    end

    assign slot = {pg_reg, sl};

    always_comb
    begin
        lnk         = (pg_reg == np_reg) ? 64'd0 : ent_reg;
        lnk[47:12]  = 36'(np_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        lvl_next       = lvl_reg;
        pg_next        = pg_reg;
        np_next        = np_reg;
        cnt_next       = cnt_reg;
        ent_next       = ent_reg;
        nfp_next       = nfp_reg;
        res_valid_next = res_valid_reg && !pop;
        rsp_next       = rsp_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        waddr          = slot;
        wdata          = 64'd0;
        raddr          = slot;

        if (cfg_we && cfg_index == REG_ALLOC)
        begin
            nfp_next = cfg_data;
        end

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (int'(cnt_reg) == STORE_ENTRIES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && !res_valid_reg)
                begin
                    q_pop     = 1'b1;
                    item_next = q_head.req;
                    rsp_next  = '0;
                    lvl_next  = 2'd0;
                    pg_next   = PG_W'(root_reg);
                    raddr     = ADDR_W'(q_head.req.entry_index);
                    case (op_t'(q_head.req.opcode))
                        OP_WRITE:
                        begin
                            we             = q_head.idx_ok;
                            waddr          = ADDR_W'(q_head.req.entry_index);
                            wdata          = q_head.req.entry_value;
                            rsp_next.status = q_head.idx_ok ? ST_OK : ST_OUTSIDE;
                            res_valid_next = 1'b1;
                        end
                        OP_READ:
                        begin
                            if (q_head.idx_ok)
                            begin
                                state_next = S_RAW;
                            end
                            else
                            begin
                                rsp_next.status = ST_OUTSIDE;
                                res_valid_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (int'(root_reg) >= TABLE_PAGES)
                            begin
                                rsp_next.status = ST_OUTSIDE;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RAW:
            begin
                rsp_next.read_data = rdata;
                res_valid_next     = 1'b1;
                state_next         = S_IDLE;
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_IDLE;
                if (op_t'(item_reg.opcode) == OP_TRANSLATE)
                begin
                    if (lvl_reg == 2'd3)
                    begin
                        rsp_next.translated_addr = {e[51:12], 12'd0}
                            + {40'd0, item_reg.virt_addr[11:0]};
                        res_valid_next = 1'b1;
                    end
                    else if (lvl_reg == 2'd1 && e[7])
                    begin
                        rsp_next.translated_addr = {e[51:12], 12'd0}
                            + {22'd0, item_reg.virt_addr[29:0]};
                        rsp_next.size_code = SZ_1G;
                        res_valid_next     = 1'b1;
                    end
                    else if (lvl_reg == 2'd2 && e[7])
                    begin
                        rsp_next.translated_addr = {e[51:12], 12'd0}
                            + {31'd0, item_reg.virt_addr[20:0]};
                        rsp_next.size_code = SZ_2M;
                        res_valid_next     = 1'b1;
                    end
                    else if (!page_ok(e))
                    begin
                        rsp_next.status = ST_OUTSIDE;
                        res_valid_next  = 1'b1;
                    end
                    else
                    begin
                        pg_next    = PG_W'(e[51:12]);
                        lvl_next   = lvl_reg + 2'd1;
                        state_next = S_RD;
                    end
                end
                else if (lvl_reg == 2'd3)
                begin
                    res_valid_next = 1'b1;
                    if (e[0] && avail_of(e) == MARK_MAPPED)
                    begin
                        rsp_next.status = ST_MAPPED;
                    end
                    else
                    begin
                        we          = 1'b1;
                        wdata       = put_avail(e, MARK_MAPPED);
                        wdata[2:0]  = 3'b111;
                        wdata[63]   = 1'b0;
                        wdata[47:12] = item_reg.target_pa[47:12];
                    end
                end
                else if (!e[0] || e[7])
                begin
                    if (int'(nfp_reg) >= TABLE_PAGES || nfp_reg >= 7'd127)
                    begin
                        rsp_next.status = ST_NOFREE;
                        res_valid_next  = 1'b1;
                    end
                    else
                    begin
                        np_next      = PG_W'(nfp_reg);
                        nfp_next     = nfp_reg + 7'd1;
                        ent_next     = put_avail(e, MARK_TABLE);
                        ent_next[2:0] = 3'b111;
                        ent_next[7]  = 1'b0;
                        ent_next[63] = 1'b0;
                        cnt_next     = '0;
                        state_next   = S_ZERO;
                    end
                end
                else if (!page_ok(e))
                begin
                    rsp_next.status = ST_OUTSIDE;
                    res_valid_next  = 1'b1;
                end
                else
                begin
                    pg_next    = PG_W'(e[51:12]);
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_ZERO:
            begin
                we       = 1'b1;
                waddr    = {np_reg, cnt_reg[8:0]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[8:0] == 9'h1ff)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                we    = 1'b1;
                wdata = lnk;
                if (lnk[51:48] != 4'd0)
                begin
                    rsp_next.status = ST_OUTSIDE;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    pg_next    = np_reg;
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        lvl_reg  <= lvl_next;
        pg_reg   <= pg_next;
        np_reg   <= np_next;
        ent_reg  <= ent_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            root_reg      <= 6'd0;
            nfp_reg       <= 7'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            nfp_reg       <= nfp_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we && cfg_index == REG_ROOT)
            begin
                root_reg <= cfg_data[5:0];
            end
        end
    end

endmodule

// ===== rtl/core/page_table_map_and_translate_core.sv =====
// channel   signals                          beat taken when
// -------   -------------------------------  ------------------
// request   push, full, req                  push && !full
// result    empty, pop, rsp                  pop && !empty
// config    cfg_we, cfg_index, cfg_data      cfg_we
//
// After reset the store is cleared one entry a cycle, all 32768 entries, with full high.
// The back takes a beat off the queue in S_IDLE; a raw write is answered there,
// a raw read goes through S_RAW, and walks read and evaluate each level (S_RD, S_EVAL).
// Map also zeroes each new table page it allocates (512-entry sweep), then links it.
// The store's single read and single write port set this sequencing.
// A two-beat request queue keeps taking beats while a result waits on pop.
module page_table_map_and_translate_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  ptmt_pkg::req_t  req,
    output logic            empty,
    input  logic            pop,
    output ptmt_pkg::rsp_t  rsp,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [6:0]      cfg_data
);
    import ptmt_pkg::*;

    logic  q_valid, q_pop, clearing, res_valid;
    work_t q_head;

    ptmt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .req     (req),
        .hold    (clearing),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    ptmt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .res_valid (res_valid),
        .rsp       (rsp),
        .pop       (pop)
    );

    assign empty = !res_valid;

endmodule

// ===== rtl/core/ptmt_checker.sv =====
module ptmt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           empty,
    input logic           pop,
    input ptmt_pkg::rsp_t rsp
);
    import ptmt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(rsp))
        else $error("result changed while waiting");

    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> rsp.size_code != 2'd3)
        else $error("bad page size");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.status != ST_OK |->
            rsp.translated_addr == 52'd0 && rsp.size_code == 2'd0
            && rsp.read_data == 64'd0)
        else $error("error result carries data");

    a_mix: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && rsp.size_code != 2'd0 |-> rsp.read_data == 64'd0)
        else $error("translate result carries read data");

endmodule

bind page_table_map_and_translate_core ptmt_checker u_ptmt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);

// ===== test/page_table_map_and_translate_core_test.sv =====
module page_table_map_and_translate_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptmt_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    req_t       req;
    logic       empty;
    logic       pop;
    rsp_t       rsp;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [6:0] cfg_data;

    page_table_map_and_translate_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req(req),
        .empty(empty),
        .pop(pop),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow of the block's table memory and registers
    logic [63:0] pt_mem [0:STORE_ENTRIES-1];
    logic [5:0]  root_pg;
    logic [6:0]  free_pg;

    req_t        pending_reqs[$];
    rsp_t        expected_rsps[$];
    logic [47:0] mapped_vas[$];
    int          errors;
    int          cycles;
    int          hold_cycles;
    logic        calm;
    logic        sent;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic ptr_page(input logic [63:0] e, output logic [5:0] pg);
        pg = e[17:12];
        return e[51:18] == '0;
    endfunction

    function automatic status_t link_table(input logic [14:0] slot, inout logic [5:0] pg);
        logic [63:0] e;
        logic [6:0]  np;
        e = pt_mem[slot];
        if (!e[0] || e[7])
        begin
            if (free_pg >= 7'(TABLE_PAGES) || free_pg == 7'd127)
                return ST_NOFREE;
            np = free_pg;
            free_pg = free_pg + 7'd1;
            e[11:8] = MARK_TABLE[4:1];
            e[62:52] = MARK_TABLE[15:5];
            e[2:0] = 3'b111;
            e[7] = 1'b0;
            e[63] = 1'b0;
            pt_mem[slot] = e;
            for (int i = 0; i < PAGE_ENTRIES; i++)
                pt_mem[{np[5:0], 9'(i)}] = '0;
            e = pt_mem[slot];
            e[47:12] = 36'(np);
            pt_mem[slot] = e;
        end
        return ptr_page(e, pg) ? ST_OK : ST_OUTSIDE;
    endfunction

    function automatic rsp_t predict_walk(input req_t r);
        rsp_t        o;
        logic [63:0] e;
        logic [5:0]  pg;
        status_t     st;
        o = '0;
        case (op_t'(r.opcode))
            OP_TRANSLATE:
            begin
                e = pt_mem[{root_pg, r.virt_addr[47:39]}];
                if (!ptr_page(e, pg))
                    o.status = ST_OUTSIDE;
                else
                begin
                    e = pt_mem[{pg, r.virt_addr[38:30]}];
                    if (e[7])
                    begin
                        o.translated_addr = {e[51:12], 12'd0} + 52'(r.virt_addr[29:0]);
                        o.size_code = SZ_1G;
                    end
                    else if (!ptr_page(e, pg))
                        o.status = ST_OUTSIDE;
                    else
                    begin
                        e = pt_mem[{pg, r.virt_addr[29:21]}];
                        if (e[7])
                        begin
                            o.translated_addr = {e[51:12], 12'd0} + 52'(r.virt_addr[20:0]);
                            o.size_code = SZ_2M;
                        end
                        else if (!ptr_page(e, pg))
                            o.status = ST_OUTSIDE;
                        else
                        begin
                            e = pt_mem[{pg, r.virt_addr[20:12]}];
                            o.translated_addr = {e[51:12], r.virt_addr[11:0]};
                        end
                    end
                end
            end
            OP_MAP:
            begin
                pg = root_pg;
                st = link_table({pg, r.virt_addr[47:39]}, pg);
                if (st == ST_OK)
                    st = link_table({pg, r.virt_addr[38:30]}, pg);
                if (st == ST_OK)
                    st = link_table({pg, r.virt_addr[29:21]}, pg);
                if (st == ST_OK)
                begin
                    e = pt_mem[{pg, r.virt_addr[20:12]}];
                    if (e[0] && {e[62:52], e[11:8], e[6]} == MARK_MAPPED)
                        st = ST_MAPPED;
                    else
                    begin
                        e[11:8] = MARK_MAPPED[4:1];
                        e[62:52] = MARK_MAPPED[15:5];
                        e[2:0] = 3'b111;
                        e[63] = 1'b0;
                        e[47:12] = r.target_pa[47:12];
                        pt_mem[{pg, r.virt_addr[20:12]}] = e;
                    end
                end
                o.status = st;
            end
            OP_WRITE: pt_mem[r.entry_index] = r.entry_value;
            default: o.read_data = pt_mem[r.entry_index];
        endcase
        return o;
    endfunction

    // accepted beats
    always @(posedge clk)
    begin
        sent = 1'b0;
        if (rst_n && push && !full)
        begin
            expected_rsps.push_back(predict_walk(req));
            sent = 1'b1;
        end
        if (rst_n && pop && !empty)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%t unexpected result beat: actual %h", $realtime, rsp);
                errors++;
            end
            else
            begin
                rsp_t x;
                x = expected_rsps.pop_front();
                if (rsp.status !== x.status)
                begin
                    $display("%t status: expected %h actual %h", $realtime, x.status,
                             rsp.status);
                    errors++;
                end
                if (rsp.translated_addr !== x.translated_addr)
                begin
                    $display("%t translated_addr: expected %h actual %h", $realtime,
                             x.translated_addr, rsp.translated_addr);
                    errors++;
                end
                if (rsp.size_code !== x.size_code)
                begin
                    $display("%t size_code: expected %h actual %h", $realtime, x.size_code,
                             rsp.size_code);
                    errors++;
                end
                if (rsp.read_data !== x.read_data)
                begin
                    $display("%t read_data: expected %h actual %h", $realtime, x.read_data,
                             rsp.read_data);
                    errors++;
                end
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (sent)
            push = 1'b0;
        if (!push && rst_n && pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 16))
        begin
            req = pending_reqs.pop_front();
            push = 1'b1;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            pop = 1'b0;
        end
        else
            pop = calm || $urandom_range(99) >= 16;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_req(input op_t op, input logic [47:0] va, input logic [51:0] pa,
                           input logic [14:0] idx, input logic [63:0] val);
        req_t r;
        r.opcode = op;
        r.virt_addr = va;
        r.target_pa = pa;
        r.entry_index = idx;
        r.entry_value = val;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [47:0] va_of(input int l4, input int l3, input int l2,
                                          input int l1, input logic [11:0] off);
        return {9'(l4), 9'(l3), 9'(l2), 9'(l1), off};
    endfunction

    task automatic drain;
        while (pending_reqs.size() != 0 || push || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [6:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == REG_ROOT)
            root_pg = val[5:0];
        else
            free_pg = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic add_random(input int n);
        logic [47:0] va;
        logic [63:0] val;
        int          pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (mapped_vas.size() != 0 && $urandom_range(1))
                va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
            else
                va = va_of($urandom_range(3), $urandom_range(3), $urandom_range(511),
                           $urandom_range(511), 12'($urandom));
            va[11:0] = 12'($urandom);
            if ($urandom_range(9) == 0)
                va = 48'({$urandom, $urandom});
            if (pick < 40)
            begin
                mapped_vas.push_back(va);
                add_req(OP_MAP, va, 52'({$urandom, $urandom}), 15'($urandom),
                        {$urandom, $urandom});
            end
            else if (pick < 75)
                add_req(OP_TRANSLATE, va, 52'({$urandom, $urandom}), 15'($urandom),
                        {$urandom, $urandom});
            else if (pick < 88)
            begin
                val = {$urandom, $urandom};
                if ($urandom_range(1))
                    val[51:12] = 40'($urandom_range(70));
                add_req(OP_WRITE, va, 52'({$urandom, $urandom}),
                        $urandom_range(4) == 0 ? 15'($urandom) : 15'($urandom_range(8 * 512 - 1)),
                        val);
            end
            else
                add_req(OP_READ, va, 52'({$urandom, $urandom}), 15'($urandom),
                        {$urandom, $urandom});
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        calm = 1'b0;
        sent = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < STORE_ENTRIES; i++)
            pt_mem[i] = '0;
        root_pg = '0;
        free_pg = 7'd1;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (full)
            @(posedge clk);

        write_reg(REG_ROOT, 7'd0);
        write_reg(REG_ALLOC, 7'd1);
        add_req(OP_TRANSLATE, '0, '0, '0, '0);
        add_req(OP_MAP, va_of(256, 1, 2, 3, 12'h0), 52'hF_FFFF_FFFF_F123, '0, '0);
        add_req(OP_MAP, va_of(256, 1, 2, 3, 12'h0), 52'h1234_5000, '0, '0);
        add_req(OP_TRANSLATE, va_of(256, 1, 2, 3, 12'habc), '0, '0, '0);
        add_req(OP_TRANSLATE, '1, '1, '1, '1);
        add_req(OP_WRITE, '0, '0, 15'h7fff, '1);
        add_req(OP_READ, '0, '0, 15'h7fff, '0);
        add_req(OP_READ, '0, '0, 15'h0, '0);
        // root entry pointing past the table store
        add_req(OP_WRITE, '0, '0, 15'd6, 64'h0000_0000_0006_4007);
        add_req(OP_TRANSLATE, va_of(6, 0, 0, 0, 12'h0), '0, '0, '0);
        add_req(OP_MAP, va_of(6, 0, 0, 0, 12'h0), '0, '0, '0);
        // 1 GiB page with wrap, then 2 MiB page
        add_req(OP_WRITE, '0, '0, 15'd7, 64'h0000_0000_0002_8001);
        add_req(OP_WRITE, '0, '0, {6'd40, 9'd0}, 64'hFFFF_FFFF_FFFF_F081);
        add_req(OP_TRANSLATE, va_of(7, 0, 511, 511, 12'hfff), '0, '0, '0);
        add_req(OP_WRITE, '0, '0, {6'd40, 9'd1}, 64'h0000_0000_0002_9001);
        add_req(OP_WRITE, '0, '0, {6'd41, 9'd0}, 64'h8000_0001_2345_6081);
        add_req(OP_TRANSLATE, va_of(7, 1, 0, 511, 12'hfff), '0, '0, '0);
        // mapping through a large page replaces it with a table
        add_req(OP_MAP, va_of(7, 0, 5, 9, 12'h0), 52'h0_ABCD_EF01_2000, '0, '0);
        add_req(OP_TRANSLATE, va_of(7, 0, 5, 9, 12'h321), '0, '0, '0);
        // present entry without the mapped marker; the map replaces the 2 MiB page and leaves it as is
        add_req(OP_WRITE, '0, '0, {6'd41, 9'd3}, 64'hFFF0_0000_0000_00C1);
        add_req(OP_MAP, va_of(7, 1, 0, 3, 12'h0), 52'h0_5555_5555_5000, '0, '0);
        add_req(OP_READ, '0, '0, {6'd41, 9'd3}, '0);
        drain();

        write_reg(REG_ROOT, 7'd63);
        write_reg(REG_ALLOC, 7'd64);
        add_req(OP_MAP, va_of(3, 3, 3, 3, 12'h0), '1, '0, '0);
        add_req(OP_TRANSLATE, va_of(3, 3, 3, 3, 12'h0), '0, '0, '0);
        add_random(20);
        drain();

        // long receiver stall while the sender keeps offering
        write_reg(REG_ROOT, 7'd2);
        write_reg(REG_ALLOC, 7'd10);
        hold_cycles = 400;
        add_random(150);
        drain();

        write_reg(REG_ROOT, 7'd0);
        write_reg(REG_ALLOC, 7'd0);
        calm = 1'b1;
        add_random(100);
        drain();
        calm = 1'b0;

        write_reg(REG_ROOT, 7'd7);
        write_reg(REG_ALLOC, 7'd20);
        add_random(160);
        drain();
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
